// ===== sv/pfci_pkg.sv =====
// ----------------------------------------------------------------------------
// pfci_pkg
// Types, command codes and sizes shared by the flash command interface.
// ----------------------------------------------------------------------------
package pfci_pkg;

   localparam int OFFSET_W = 19;
   localparam int DATA_W   = 8;

   localparam int DEF_ARRAY_BYTES  = 524288;
   localparam int DEF_SECTOR_BYTES = 4096;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [OFFSET_W-1:0] CMD_ADDR1 = 19'h05555;
   localparam logic [OFFSET_W-1:0] CMD_ADDR2 = 19'h02aaa;

   localparam logic [DATA_W-1:0] CMD_UNLOCK1       = 8'haa;
   localparam logic [DATA_W-1:0] CMD_UNLOCK2       = 8'h55;
   localparam logic [DATA_W-1:0] CMD_ID_ENTRY      = 8'h90;
   localparam logic [DATA_W-1:0] CMD_ERASE_SETUP   = 8'h80;
   localparam logic [DATA_W-1:0] CMD_SECTOR_ERASE  = 8'h30;
   localparam logic [DATA_W-1:0] CMD_BYTE_PROGRAM  = 8'ha0;
   localparam logic [DATA_W-1:0] MANUFACTURER_CODE = 8'hbf;
   localparam logic [DATA_W-1:0] ERASED_BYTE       = 8'hff;
   localparam logic [DATA_W-1:0] DEVICE_CODE_RESET = 8'hd7;

   typedef enum logic [2:0] {
      PH_READ,
      PH_UNLOCK1,
      PH_UNLOCK2,
      PH_ID,
      PH_PROGRAM,
      PH_ERASE_SETUP,
      PH_ERASE_UNLOCK1,
      PH_ERASE_UNLOCK2
   } phase_type;

   typedef enum logic [2:0] {
      OP_READ,
      OP_ID,
      OP_NONE,
      OP_PROGRAM,
      OP_ERASE
   } op_kind_type;

   typedef struct packed {
      op_kind_type               kind;
      logic [OFFSET_W-1:0]       offset;
      logic [DATA_W-1:0]         data;
   } op_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_REDUCE,
      B_SECTOR,
      B_ERASE,
      B_READ_WAIT,
      B_PROG_WAIT
   } back_state_type;

   typedef struct packed {
      logic init_busy;
   } back_status_type;

endpackage

// ===== sv/pfci_ram.sv =====
// ----------------------------------------------------------------------------
// pfci_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pfci_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/pfci_queue.sv =====
// ----------------------------------------------------------------------------
// pfci_queue
// Short FIFO of decoded operations between the command decoder and the
// array sequencer.
// ----------------------------------------------------------------------------
module pfci_queue
   import pfci_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   input  logic   push,
   input  op_type push_op,
   output logic   full,
   output logic   head_valid,
   input  logic   pop,
   output op_type head_op
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   op_type          slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

   assign full       = (count_ff == CW'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_op    = slot_ff[rd_ptr_ff];

endmodule

// ===== sv/pfci_front.sv =====
// ----------------------------------------------------------------------------
// pfci_front
// Command decoder: accepts bus beats, tracks the unlock sequence and hands
// one decoded operation per beat to the queue.
// ----------------------------------------------------------------------------
module pfci_front
   import pfci_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_func,
   input  logic [OFFSET_W-1:0] req_byte_offset,
   input  logic [DATA_W-1:0]   req_write_byte,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [DATA_W-1:0]   csr_data,
   input  back_status_type     back_status,
   input  logic                queue_full,
   output logic                queue_push,
   output op_type              queue_op
);

   phase_type         phase_ff, phase_in;
   logic [DATA_W-1:0] device_code_ff;
   logic              accept;
   logic              at1;
   logic              at2;

   assign req_stall  = queue_full || back_status.init_busy;
   assign accept     = req_valid && !req_stall;
   assign queue_push = accept;
   assign csr_ready  = 1'b1;
   assign at1        = (req_byte_offset == CMD_ADDR1);
   assign at2        = (req_byte_offset == CMD_ADDR2);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_READ;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         device_code_ff <= DEVICE_CODE_RESET;
      end else if (csr_valid) begin
         device_code_ff <= csr_data;
      end
   end

   always_comb begin
      phase_in        = phase_ff;
      queue_op.kind   = OP_NONE;
      queue_op.offset = req_byte_offset;
      queue_op.data   = req_write_byte;
      if (!req_func) begin
         if (phase_ff == PH_ID) begin
            queue_op.kind = OP_ID;
            queue_op.data = req_byte_offset[0] ? device_code_ff : MANUFACTURER_CODE;
         end else begin
            queue_op.kind = OP_READ;
         end
      end else begin
         if (accept) begin
            phase_in = PH_READ;
         end
         case (phase_ff)
            PH_READ, PH_ID: begin
               if (accept && at1 && req_write_byte == CMD_UNLOCK1) begin
                  phase_in = PH_UNLOCK1;
               end
            end
            PH_UNLOCK1: begin
               if (accept && at2 && req_write_byte == CMD_UNLOCK2) begin
                  phase_in = PH_UNLOCK2;
               end
            end
            PH_UNLOCK2: begin
               if (accept && at1) begin
                  if (req_write_byte == CMD_ID_ENTRY) begin
                     phase_in = PH_ID;
                  end else if (req_write_byte == CMD_BYTE_PROGRAM) begin
                     phase_in = PH_PROGRAM;
                  end else if (req_write_byte == CMD_ERASE_SETUP) begin
                     phase_in = PH_ERASE_SETUP;
                  end
               end
            end
            PH_PROGRAM: begin
               queue_op.kind = OP_PROGRAM;
            end
            PH_ERASE_SETUP: begin
               if (accept && at1 && req_write_byte == CMD_UNLOCK1) begin
                  phase_in = PH_ERASE_UNLOCK1;
               end
            end
            PH_ERASE_UNLOCK1: begin
               if (accept && at2 && req_write_byte == CMD_UNLOCK2) begin
                  phase_in = PH_ERASE_UNLOCK2;
               end
            end
            PH_ERASE_UNLOCK2: begin
               if (req_write_byte == CMD_SECTOR_ERASE) begin
                  queue_op.kind = OP_ERASE;
               end
            end
            default: begin
               phase_in = PH_READ;
            end
         endcase
      end
   end

endmodule

// ===== sv/pfci_back.sv =====
// ----------------------------------------------------------------------------
// pfci_back
// Array sequencer: owns the flash array RAM, reduces offsets to array and
// sector positions, runs reads, read-modify-write programs, sector erases
// and the clearing pass after reset, and holds the result beat.
// ----------------------------------------------------------------------------
module pfci_back
   import pfci_pkg::*;
#(
   parameter int ARRAY_BYTES  = DEF_ARRAY_BYTES,
   parameter int SECTOR_BYTES = DEF_SECTOR_BYTES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              queue_valid,
   input  op_type            queue_op,
   output logic              queue_pop,
   output back_status_type   back_status,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [DATA_W-1:0] rsp_read_byte,
   output logic              rsp_program_fault
);

   localparam int AW    = $clog2(ARRAY_BYTES);
   localparam int RW    = (AW > OFFSET_W) ? AW : OFFSET_W;
   localparam int ARR_K = $clog2(((2 ** OFFSET_W) + ARRAY_BYTES - 1) / ARRAY_BYTES);
   localparam int SEC_K = $clog2((ARRAY_BYTES + SECTOR_BYTES - 1) / SECTOR_BYTES);
   localparam int KMAX  = (ARR_K > SEC_K) ? ARR_K : SEC_K;
   localparam int SW    = (KMAX < 1) ? 1 : $clog2(KMAX + 1);
   localparam logic [RW-1:0] ARR_SUB_INIT = RW'(ARRAY_BYTES * ((2 ** ARR_K) / 2));
   localparam logic [RW-1:0] SEC_SUB_INIT = RW'(SECTOR_BYTES * ((2 ** SEC_K) / 2));

   back_state_type    state_ff, state_in;
   op_type            op_ff, op_in;
   logic [AW-1:0]     idx_ff, idx_in;
   logic [RW-1:0]     red_ff, red_in;
   logic [RW-1:0]     sub_ff, sub_in;
   logic [SW-1:0]     step_ff, step_in;
   logic [AW-1:0]     cnt_ff, cnt_in;
   logic [AW:0]       last_ff, last_in;
   logic              init_ff, init_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic              rsp_fault_ff, rsp_fault_in;

   logic              slot_free;
   logic              acc_now;
   op_kind_type       acc_kind;
   logic [AW-1:0]     acc_idx;
   logic [AW-1:0]     sector_base;

   logic              ram_wr_en;
   logic [AW-1:0]     ram_wr_addr;
   logic [DATA_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [AW-1:0]     ram_rd_addr;
   logic [DATA_W-1:0] ram_rd_data;

   pfci_ram #(
      .WIDTH (DATA_W),
      .DEPTH (ARRAY_BYTES)
   ) u_array (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign slot_free   = !rsp_valid_ff || !rsp_stall;
   assign sector_base = idx_ff - red_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_ERASE;
         init_ff      <= 1'b1;
         cnt_ff       <= '0;
         last_ff      <= (AW+1)'(ARRAY_BYTES - 1);
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         cnt_ff       <= cnt_in;
         last_ff      <= last_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      idx_ff       <= idx_in;
      red_ff       <= red_in;
      sub_ff       <= sub_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_fault_ff <= rsp_fault_in;
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      idx_in       = idx_ff;
      red_in       = red_ff;
      sub_in       = sub_ff;
      step_in      = step_ff;
      cnt_in       = cnt_ff;
      last_in      = last_ff;
      init_in      = init_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_byte_in  = rsp_byte_ff;
      rsp_fault_in = rsp_fault_ff;
      queue_pop    = 1'b0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = cnt_ff;
      ram_wr_data  = ERASED_BYTE;
      ram_rd_en    = 1'b0;
      acc_now      = 1'b0;
      acc_kind     = op_ff.kind;
      acc_idx      = red_ff[AW-1:0];

      case (state_ff)
         B_IDLE: begin
            if (queue_valid && slot_free) begin
               queue_pop = 1'b1;
               op_in     = queue_op;
               case (queue_op.kind)
                  OP_ID: begin
                     rsp_valid_in = 1'b1;
                     rsp_byte_in  = queue_op.data;
                     rsp_fault_in = 1'b0;
                  end
                  OP_NONE: begin
                     rsp_valid_in = 1'b1;
                     rsp_byte_in  = '0;
                     rsp_fault_in = 1'b0;
                  end
                  default: begin
                     if (ARR_K == 0) begin
                        acc_now  = 1'b1;
                        acc_kind = queue_op.kind;
                        acc_idx  = AW'(queue_op.offset);
                     end else begin
                        red_in   = RW'(queue_op.offset);
                        sub_in   = ARR_SUB_INIT;
                        step_in  = SW'(ARR_K);
                        state_in = B_REDUCE;
                     end
                  end
               endcase
            end
         end
         B_REDUCE: begin
            if (step_ff != '0) begin
               if (red_ff >= sub_ff) begin
                  red_in = red_ff - sub_ff;
               end
               sub_in  = sub_ff >> 1;
               step_in = step_ff - 1'b1;
            end else begin
               acc_now = 1'b1;
            end
         end
         B_SECTOR: begin
            if (step_ff != '0) begin
               if (red_ff >= sub_ff) begin
                  red_in = red_ff - sub_ff;
               end
               sub_in  = sub_ff >> 1;
               step_in = step_ff - 1'b1;
            end else begin
               cnt_in       = sector_base;
               last_in      = {1'b0, sector_base} + (AW+1)'(SECTOR_BYTES - 1);
               rsp_valid_in = 1'b1;
               rsp_byte_in  = '0;
               rsp_fault_in = 1'b0;
               state_in     = B_ERASE;
            end
         end
         B_ERASE: begin
            ram_wr_en = 1'b1;
            cnt_in    = cnt_ff + 1'b1;
            if ({1'b0, cnt_ff} == last_ff || cnt_ff == AW'(ARRAY_BYTES - 1)) begin
               init_in  = 1'b0;
               state_in = B_IDLE;
            end
         end
         B_READ_WAIT: begin
            rsp_valid_in = 1'b1;
            rsp_byte_in  = ram_rd_data;
            rsp_fault_in = 1'b0;
            state_in     = B_IDLE;
         end
         B_PROG_WAIT: begin
            ram_wr_en    = 1'b1;
            ram_wr_addr  = idx_ff;
            ram_wr_data  = ram_rd_data & op_ff.data;
            rsp_valid_in = 1'b1;
            rsp_byte_in  = '0;
            rsp_fault_in = |(op_ff.data & ~ram_rd_data);
            state_in     = B_IDLE;
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase

      ram_rd_addr = acc_idx;
      if (acc_now) begin
         idx_in = acc_idx;
         case (acc_kind)
            OP_READ: begin
               ram_rd_en = 1'b1;
               state_in  = B_READ_WAIT;
            end
            OP_PROGRAM: begin
               ram_rd_en = 1'b1;
               state_in  = B_PROG_WAIT;
            end
            OP_ERASE: begin
               red_in   = RW'(acc_idx);
               sub_in   = SEC_SUB_INIT;
               step_in  = SW'(SEC_K);
               state_in = B_SECTOR;
            end
            default: begin
               state_in = B_IDLE;
            end
         endcase
      end
   end

   assign back_status.init_busy = init_ff;
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_read_byte         = rsp_byte_ff;
   assign rsp_program_fault     = rsp_fault_ff;

endmodule

// ===== sv/parallel_flash_command_interface.sv =====
// ----------------------------------------------------------------------------
// parallel_flash_command_interface
// Byte-wide NOR flash command set: unlock sequence, ID mode, byte program
// and sector erase over an on-chip array.
// ----------------------------------------------------------------------------
// After reset the block sweeps the whole array to the erased value, one byte
// per cycle, and stalls the request channel meanwhile; the register port is
// open throughout. Every request beat yields exactly one response beat. The
// decoder takes one beat per cycle, while not stalled, into a two-entry queue;
// the array sequencer then answers ID reads and command writes directly, does
// an array read as a RAM read and a result step, and a program as a read, then
// a write back of the ANDed byte on the array RAM port. A sector erase first
// takes as many steps as log2 of the sector count to find the sector position,
// then writes one byte a cycle over the sector. If ARRAY_BYTES is smaller than
// the offset space, each array access and erase first reduces the offset, in
// steps numbering log2 of the ratio of offset space to array size.
// ----------------------------------------------------------------------------
module parallel_flash_command_interface
   import pfci_pkg::*;
#(
   parameter int ARRAY_BYTES  = DEF_ARRAY_BYTES,
   parameter int SECTOR_BYTES = DEF_SECTOR_BYTES
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_func,
   input  logic [OFFSET_W-1:0] req_byte_offset,
   input  logic [DATA_W-1:0]   req_write_byte,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [DATA_W-1:0]   rsp_read_byte,
   output logic                rsp_program_fault,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [DATA_W-1:0]   csr_data
);

   back_status_type back_status;
   logic            queue_full;
   logic            queue_push;
   op_type          push_op;
   logic            queue_valid;
   logic            queue_pop;
   op_type          head_op;

   pfci_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_byte_offset (req_byte_offset),
      .req_write_byte  (req_write_byte),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data),
      .back_status     (back_status),
      .queue_full      (queue_full),
      .queue_push      (queue_push),
      .queue_op        (push_op)
   );

   pfci_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (queue_push),
      .push_op    (push_op),
      .full       (queue_full),
      .head_valid (queue_valid),
      .pop        (queue_pop),
      .head_op    (head_op)
   );

   pfci_back #(
      .ARRAY_BYTES  (ARRAY_BYTES),
      .SECTOR_BYTES (SECTOR_BYTES)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .queue_valid       (queue_valid),
      .queue_op          (head_op),
      .queue_pop         (queue_pop),
      .back_status       (back_status),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_read_byte     (rsp_read_byte),
      .rsp_program_fault (rsp_program_fault)
   );

endmodule
